/* hw/rtl/abag_pkg.sv */
`default_nettype none

package abag_pkg;

    localparam logic [2:0] REG_STEP_X_DX    = 3'd0;
    localparam logic [2:0] REG_STEP_Y_DX    = 3'd1;
    localparam logic [2:0] REG_MOSAIC_ON    = 3'd2;
    localparam logic [2:0] REG_MOSAIC_WIDTH = 3'd3;
    localparam logic [2:0] REG_WRAP_ON      = 3'd4;
    localparam logic [2:0] REG_SIZE_CODE    = 3'd5;
    localparam logic [2:0] REG_LAYER_MODE   = 3'd6;
    localparam logic [2:0] REG_BASE_ADDRESS = 3'd7;

    localparam logic [2:0] MODE_AFFINE_MAP   = 3'd0;
    localparam logic [2:0] MODE_EXTENDED_MAP = 3'd1;
    localparam logic [2:0] MODE_DIRECT_BMP   = 3'd2;
    localparam logic [2:0] MODE_PALETTE_BMP  = 3'd3;
    localparam logic [2:0] MODE_LARGE_BMP    = 3'd4;

    localparam int POINT_BITS = 28;
    localparam int COORD_BITS = 20;
    localparam int TEXEL_BITS = 10;
    localparam int FETCH_BITS = 19;
    localparam int SUM_BITS   = 21;

    typedef struct packed {
        logic [FETCH_BITS-1:0] fetch_address;
        logic [TEXEL_BITS-1:0] texel_y;
        logic [TEXEL_BITS-1:0] texel_x;
        logic                  outside;
    } texel_t;

endpackage

`default_nettype wire

/* hw/rtl/affine_background_address_generator.sv */
`default_nettype none

// Affine background address generator. A word on the slave side with tuser 0 loads the
// signed 20.8 reference point and starts a line; a word with tuser 1 renders the next pixel
// and gives one result word: the layer coordinate after wrap, the outside flag in tuser, the
// first VRAM byte address for the selected layer mode, and tlast on the last pixel of the
// line. Pixel words after the end of a line give nothing until the next line start. One word
// is taken every clock unless the result port stalls; a result passes through the pixel
// register and then the result register. The point update at the input (a 28-bit add fed
// by a 5 by 16 mosaic multiply) runs beside the pixel register, and the address logic sits
// between the pixel register and the result register. Configuration is written through the
// cfg port, always ready; the user must write it only while the block is idle, unenforced.
module affine_background_address_generator #(
    parameter int LINE_PIXELS    = 256,
    parameter int VRAM_ADDR_BITS = 19
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // start_x[27:0], start_y[55:28]
    input  wire logic        s_tuser,   // command[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // screen_column[7:0], texel_x[17:8],
                                        // texel_y[27:18], fetch_address[46:28], zero[47]
    output logic             m_tuser,   // outside[0]
    output logic             m_tlast,   // line_done
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [18:0] cfg_data
);

    localparam int CW = $clog2(LINE_PIXELS + 1);
    localparam int PB = abag_pkg::POINT_BITS;
    localparam int CB = abag_pkg::COORD_BITS;
    localparam int TB = abag_pkg::TEXEL_BITS;
    localparam int SB = abag_pkg::SUM_BITS;
    localparam int FB = abag_pkg::FETCH_BITS;
    localparam logic [SB-1:0] ADDR_MASK =
        (VRAM_ADDR_BITS >= SB) ? {SB{1'b1}} : SB'((64'd1 << VRAM_ADDR_BITS) - 64'd1);

    // configuration
    logic signed [15:0] step_x_dx_reg;
    logic signed [15:0] step_y_dx_reg;
    logic               mosaic_on_reg;
    logic [4:0]         mosaic_width_reg;
    logic               wrap_on_reg;
    logic [1:0]         size_code_reg;
    logic [2:0]         layer_mode_reg;
    logic [18:0]        base_address_reg;

    // line state
    logic [PB-1:0] point_x_reg, point_x_next;
    logic [PB-1:0] point_y_reg, point_y_next;
    logic [4:0]    mosaic_count_reg, mosaic_count_next;
    logic [CW-1:0] column_count_reg, column_count_next;

    // pixel stage
    logic          pix_valid_reg;
    logic [CW-1:0] pix_col_reg;
    logic [CB-1:0] pix_ix_reg;
    logic [CB-1:0] pix_iy_reg;

    // result stage
    logic                 out_valid_reg;
    logic [CW-1:0]        out_col_reg;
    abag_pkg::texel_t     out_texel_reg, out_texel_next;

    logic          out_adv;
    logic          pix_load;
    logic          in_accept;
    logic          pixel_take;
    logic          line_start;
    logic          mosaic_hit;
    logic [4:0]    mosaic_inc;
    logic signed [21:0] mos_step_x;
    logic signed [21:0] mos_step_y;

    assign cfg_ready  = 1'b1;
    assign out_adv    = !out_valid_reg || m_tready;
    assign pix_load   = out_adv || !pix_valid_reg;
    assign s_tready   = pix_load;
    assign in_accept  = s_tvalid && s_tready;
    assign line_start = in_accept && !s_tuser;
    assign pixel_take = in_accept && s_tuser && (column_count_reg < CW'(LINE_PIXELS));

    assign mosaic_inc = mosaic_count_reg + 5'd1;
    assign mosaic_hit = mosaic_inc == mosaic_width_reg;
    assign mos_step_x = $signed({1'b0, mosaic_width_reg}) * step_x_dx_reg;
    assign mos_step_y = $signed({1'b0, mosaic_width_reg}) * step_y_dx_reg;

    always_comb
    begin
        point_x_next      = point_x_reg;
        point_y_next      = point_y_reg;
        mosaic_count_next = mosaic_count_reg;
        column_count_next = column_count_reg;
        if (line_start)
        begin
            point_x_next      = s_tdata[27:0];
            point_y_next      = s_tdata[55:28];
            mosaic_count_next = 5'd0;
            column_count_next = '0;
        end
        else if (pixel_take)
        begin
            column_count_next = column_count_reg + CW'(1);
            if (mosaic_on_reg)
            begin
                mosaic_count_next = mosaic_inc;
                if (mosaic_hit)
                begin
                    point_x_next      = point_x_reg + PB'(mos_step_x);
                    point_y_next      = point_y_reg + PB'(mos_step_y);
                    mosaic_count_next = 5'd0;
                end
            end
            else
            begin
                point_x_next = point_x_reg + PB'(step_x_dx_reg);
                point_y_next = point_y_reg + PB'(step_y_dx_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_dx_reg    <= 16'sd256;
            step_y_dx_reg    <= 16'sd0;
            mosaic_on_reg    <= 1'b0;
            mosaic_width_reg <= 5'd1;
            wrap_on_reg      <= 1'b0;
            size_code_reg    <= 2'd0;
            layer_mode_reg   <= abag_pkg::MODE_AFFINE_MAP;
            base_address_reg <= 19'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                abag_pkg::REG_STEP_X_DX:    step_x_dx_reg    <= $signed(cfg_data[15:0]);
                abag_pkg::REG_STEP_Y_DX:    step_y_dx_reg    <= $signed(cfg_data[15:0]);
                abag_pkg::REG_MOSAIC_ON:    mosaic_on_reg    <= cfg_data[0];
                abag_pkg::REG_MOSAIC_WIDTH: mosaic_width_reg <= cfg_data[4:0];
                abag_pkg::REG_WRAP_ON:      wrap_on_reg      <= cfg_data[0];
                abag_pkg::REG_SIZE_CODE:    size_code_reg    <= cfg_data[1:0];
                abag_pkg::REG_LAYER_MODE:   layer_mode_reg   <= cfg_data[2:0];
                abag_pkg::REG_BASE_ADDRESS: base_address_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_x_reg      <= '0;
            point_y_reg      <= '0;
            mosaic_count_reg <= '0;
            column_count_reg <= '0;
            pix_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            point_x_reg      <= point_x_next;
            point_y_reg      <= point_y_next;
            mosaic_count_reg <= mosaic_count_next;
            column_count_reg <= column_count_next;
            if (pix_load)
            begin
                pix_valid_reg <= pixel_take;
            end
            if (out_adv)
            begin
                out_valid_reg <= pix_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_load && pixel_take)
        begin
            pix_col_reg <= column_count_reg;
            pix_ix_reg  <= point_x_reg[PB-1:8];
            pix_iy_reg  <= point_y_reg[PB-1:8];
        end
        if (out_adv && pix_valid_reg)
        begin
            out_col_reg   <= pix_col_reg;
            out_texel_reg <= out_texel_next;
        end
    end

    // layer size and address
    logic [3:0]    width_log;
    logic [3:0]    height_log;
    logic [CB-1:0] width_full;
    logic [CB-1:0] height_full;
    logic          mode_valid;
    logic          clip;
    logic [TB-1:0] tx;
    logic [TB-1:0] ty;
    logic [SB-1:0] row_offset;
    logic [SB-1:0] map_offset;
    logic [SB-1:0] base_ext;
    logic [SB-1:0] addr_sum;

    always_comb
    begin
        mode_valid = 1'b1;
        case (layer_mode_reg)
            abag_pkg::MODE_AFFINE_MAP, abag_pkg::MODE_EXTENDED_MAP:
            begin
                width_log  = 4'd7 + {2'b00, size_code_reg};
                height_log = width_log;
            end
            abag_pkg::MODE_DIRECT_BMP, abag_pkg::MODE_PALETTE_BMP:
            begin
                case (size_code_reg)
                    2'd0:    begin width_log = 4'd7; height_log = 4'd7; end
                    2'd1:    begin width_log = 4'd8; height_log = 4'd8; end
                    2'd2:    begin width_log = 4'd9; height_log = 4'd8; end
                    default: begin width_log = 4'd9; height_log = 4'd9; end
                endcase
            end
            abag_pkg::MODE_LARGE_BMP:
            begin
                width_log  = 4'd9 + {3'b000, size_code_reg[0]};
                height_log = 4'd10 - {3'b000, size_code_reg[0]};
            end
            default:
            begin
                width_log  = 4'd7;
                height_log = 4'd7;
                mode_valid = 1'b0;
            end
        endcase
        width_full  = CB'(1) << width_log;
        height_full = CB'(1) << height_log;

        clip = pix_ix_reg[CB-1] || pix_iy_reg[CB-1]
            || (pix_ix_reg >= width_full) || (pix_iy_reg >= height_full);

        out_texel_next.outside = !mode_valid || (!wrap_on_reg && clip);
        if (wrap_on_reg)
        begin
            tx = pix_ix_reg[TB-1:0] & TB'(width_full - CB'(1));
            ty = pix_iy_reg[TB-1:0] & TB'(height_full - CB'(1));
        end
        else
        begin
            tx = pix_ix_reg[TB-1:0];
            ty = pix_iy_reg[TB-1:0];
        end

        row_offset = (SB'(ty) << width_log) + SB'(tx);
        map_offset = (SB'(ty[TB-1:3]) << (3'd4 + {1'b0, size_code_reg})) + SB'(tx[TB-1:3]);
        base_ext   = SB'(base_address_reg);
        case (layer_mode_reg)
            abag_pkg::MODE_AFFINE_MAP:   addr_sum = base_ext + map_offset;
            abag_pkg::MODE_EXTENDED_MAP: addr_sum = base_ext + (map_offset << 1);
            abag_pkg::MODE_DIRECT_BMP:   addr_sum = base_ext + (row_offset << 1);
            abag_pkg::MODE_PALETTE_BMP:  addr_sum = base_ext + row_offset;
            default:                     addr_sum = row_offset;
        endcase

        if (out_texel_next.outside)
        begin
            out_texel_next.texel_x       = '0;
            out_texel_next.texel_y       = '0;
            out_texel_next.fetch_address = '0;
        end
        else
        begin
            out_texel_next.texel_x       = tx;
            out_texel_next.texel_y       = ty;
            out_texel_next.fetch_address = FB'(addr_sum & ADDR_MASK);
        end
    end

    // result port
    logic [CW+7:0] col_ext;

    assign col_ext  = {8'd0, out_col_reg};
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_texel_reg.fetch_address, out_texel_reg.texel_y,
                       out_texel_reg.texel_x, col_ext[7:0]};
    assign m_tuser  = out_texel_reg.outside;
    assign m_tlast  = out_col_reg == CW'(LINE_PIXELS - 1);

endmodule

`default_nettype wire
